FILE: rtl/gnta_pkg.sv
// ----------------------------------------------------------------------------
// gnta_pkg
// Shared types and constants of the gated nearest track association unit.
// ----------------------------------------------------------------------------
package gnta_pkg;

   localparam int MAX_POSES  = 64;
   localparam int POS_W      = $clog2(MAX_POSES + 1);
   localparam int COORD_W    = 24;
   localparam int VAR_W      = 32;
   localparam int SQ_W       = 2 * COORD_W + 1;
   localparam int GATE_W     = VAR_W + 3;
   localparam int DIST_W     = 50;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 8;

   localparam logic [COUNT_W-1:0] FAIL_LIMIT_RESET = COUNT_W'(5);
   localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

   typedef enum logic [1:0] {
      OUTCOME_NO_TRACK = 2'd0,
      OUTCOME_MATCHED  = 2'd1,
      OUTCOME_NO_MATCH = 2'd2,
      OUTCOME_DROP     = 2'd3
   } outcome_type;

   // raw request as held in the input register
   typedef struct packed {
      logic signed [COORD_W-1:0] pose_x;
      logic signed [COORD_W-1:0] pose_y;
      logic signed [COORD_W-1:0] est_x;
      logic signed [COORD_W-1:0] est_y;
      logic        [VAR_W-1:0]   var_x;
      logic        [VAR_W-1:0]   var_y;
      logic                      tracking_active;
      logic                      has_pose;
      logic                      last_item;
   } req_type;

   // request after the distance stage
   typedef struct packed {
      logic [SQ_W-1:0]   dist_sq;
      logic [GATE_W-1:0] gate;
      logic              tracking_active;
      logic              has_pose;
      logic              last_item;
   } cand_type;

endpackage

FILE: rtl/gnta_dist.sv
// ----------------------------------------------------------------------------
// gnta_dist
// Squared distance from the estimate and the gate 4*(var_x+var_y), registered.
// ----------------------------------------------------------------------------
module gnta_dist
   import gnta_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_req,
   output logic     out_valid,
   input  logic     out_ready,
   output cand_type out_cand
);

   logic                    valid_ff;
   logic                    valid_in;
   cand_type                cand_ff;
   cand_type                cand_in;
   logic signed [COORD_W:0] diff_x;
   logic signed [COORD_W:0] diff_y;
   logic [COORD_W-1:0]      abs_x;
   logic [COORD_W-1:0]      abs_y;
   logic [2*COORD_W-1:0]    sq_x;
   logic [2*COORD_W-1:0]    sq_y;
   logic [VAR_W:0]          var_sum;

   always_comb begin
      diff_x  = (COORD_W+1)'(in_req.pose_x) - (COORD_W+1)'(in_req.est_x);
      diff_y  = (COORD_W+1)'(in_req.pose_y) - (COORD_W+1)'(in_req.est_y);
      abs_x   = diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
      abs_y   = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
      sq_x    = abs_x * abs_x;
      sq_y    = abs_y * abs_y;
      var_sum = (VAR_W+1)'(in_req.var_x) + (VAR_W+1)'(in_req.var_y);
      cand_in.dist_sq         = SQ_W'(sq_x) + SQ_W'(sq_y);
      cand_in.gate            = {var_sum, 2'b00};
      cand_in.tracking_active = in_req.tracking_active;
      cand_in.has_pose        = in_req.has_pose;
      cand_in.last_item       = in_req.last_item;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = (in_valid && in_ready) ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cand_ff <= cand_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_cand  = cand_ff;

endmodule

FILE: rtl/gnta_select.sv
// ----------------------------------------------------------------------------
// gnta_select
// Running gated minimum over a message, fail counter and result register.
// ----------------------------------------------------------------------------
module gnta_select
   import gnta_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] fail_limit,
   input  logic               in_valid,
   output logic               in_ready,
   input  cand_type           in_cand,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output outcome_type        rsp_outcome,
   output logic [INDEX_W-1:0] rsp_match_index,
   output logic [COUNT_W-1:0] rsp_fail_count
);

   logic [DIST_W-1:0]      best_dist_ff, best_dist_in;
   logic [POS_W-1:0]       best_idx_ff, best_idx_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   found_ff, found_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   valid_ff, valid_in;
   outcome_type            outcome_ff, outcome_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic [COUNT_W-1:0]     fail_ff, fail_in;
   logic                   fire;
   logic                   consider;
   logic                   take;
   logic                   cur_found;
   logic [POS_W-1:0]       cur_idx;
   logic [POS_W+INDEX_W-1:0] idx_ext;

   // a last request can only be taken when the result register is free or being read
   assign in_ready = !in_cand.last_item || !valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      consider  = fire && in_cand.has_pose && (pos_ff < POS_W'(MAX_POSES));
      take      = consider && (DIST_W'(in_cand.dist_sq) < best_dist_ff)
                  && (in_cand.dist_sq < SQ_W'(in_cand.gate));
      cur_found = found_ff || take;
      cur_idx   = take ? pos_ff : best_idx_ff;
      idx_ext   = {{INDEX_W{1'b0}}, cur_idx};

      best_dist_in = take ? DIST_W'(in_cand.dist_sq) : best_dist_ff;
      best_idx_in  = cur_idx;
      found_in     = cur_found;
      pos_in       = consider ? pos_ff + POS_W'(1) : pos_ff;
      count_in     = count_ff;
      outcome_in   = outcome_ff;
      index_in     = index_ff;
      fail_in      = fail_ff;
      valid_in     = rsp_ready ? 1'b0 : valid_ff;

      if (fire && in_cand.last_item) begin
         index_in = '0;
         if (count_ff >= fail_limit) begin
            count_in   = '0;
            outcome_in = OUTCOME_DROP;
         end else if (!in_cand.tracking_active) begin
            outcome_in = OUTCOME_NO_TRACK;
         end else if (cur_found) begin
            count_in   = '0;
            outcome_in = OUTCOME_MATCHED;
            index_in   = idx_ext[INDEX_W-1:0];
         end else begin
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
            outcome_in = OUTCOME_NO_MATCH;
         end
         fail_in  = count_in;
         valid_in = 1'b1;
         // message done: return the search to its idle values
         best_dist_in = '1;
         best_idx_in  = '0;
         found_in     = 1'b0;
         pos_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff <= '1;
         best_idx_ff  <= '0;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         valid_ff     <= 1'b0;
      end else begin
         best_dist_ff <= best_dist_in;
         best_idx_ff  <= best_idx_in;
         pos_ff       <= pos_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
      index_ff   <= index_in;
      fail_ff    <= fail_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_outcome     = outcome_ff;
   assign rsp_match_index = index_ff;
   assign rsp_fail_count  = fail_ff;

endmodule

FILE: rtl/gated_nearest_track_association_unit.sv
// ----------------------------------------------------------------------------
// gated_nearest_track_association_unit
// Gated nearest-candidate association of one detection message to a track.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel, one candidate position per request,
// with the track estimate, its variances and the message flags. A candidate
// is kept when its squared distance to the estimate is below
// 4*(var_x+var_y) and below the best so far; the earliest wins a tie.
// The request carrying last_item produces one response on the rsp_ channel
// (no track, matched with index, no match, or drop track) plus the fail
// counter; other requests produce none.
// Pipeline: input register, distance register, result register. A response
// is formed from its last request after the input and distance registers; one
// request is accepted every cycle while nothing stalls. The running-minimum
// update and the fail counter are the only loops, both in the select stage.
// When rsp_ready is low the response holds; requests keep flowing until a
// further last request reaches the select stage, then the pipeline stalls.
// Reset empties the pipeline, clears the fail counter and the search state
// and sets fail_limit to 5. csr_write_enable writes fail_limit at once.
// ----------------------------------------------------------------------------
module gated_nearest_track_association_unit
   import gnta_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_pose_x,
   input  logic signed [COORD_W-1:0] req_pose_y,
   input  logic signed [COORD_W-1:0] req_est_x,
   input  logic signed [COORD_W-1:0] req_est_y,
   input  logic        [VAR_W-1:0]   req_var_x,
   input  logic        [VAR_W-1:0]   req_var_y,
   input  logic                      req_tracking_active,
   input  logic                      req_has_pose,
   input  logic                      req_last_item,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_outcome,
   output logic [INDEX_W-1:0]        rsp_match_index,
   output logic [COUNT_W-1:0]        rsp_fail_count,
   input  logic                      csr_write_enable,
   input  logic [COUNT_W-1:0]        csr_write_data
);

   logic [COUNT_W-1:0] fail_limit_ff;
   logic               req_valid_ff;
   logic               req_valid_in;
   req_type            req_ff;
   req_type            req_in;
   logic               dist_ready;
   logic               cand_valid;
   logic               cand_ready;
   cand_type           cand;
   outcome_type        outcome;

   always_comb begin
      req_in.pose_x          = req_pose_x;
      req_in.pose_y          = req_pose_y;
      req_in.est_x           = req_est_x;
      req_in.est_y           = req_est_y;
      req_in.var_x           = req_var_x;
      req_in.var_y           = req_var_y;
      req_in.tracking_active = req_tracking_active;
      req_in.has_pose        = req_has_pose;
      req_in.last_item       = req_last_item;
   end

   assign req_ready    = !req_valid_ff || dist_ready;
   assign req_valid_in = (req_valid && req_ready) ? 1'b1 :
                         (dist_ready ? 1'b0 : req_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         fail_limit_ff <= FAIL_LIMIT_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         if (csr_write_enable) begin
            fail_limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
   end

   gnta_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_ready  (dist_ready),
      .in_req    (req_ff),
      .out_valid (cand_valid),
      .out_ready (cand_ready),
      .out_cand  (cand)
   );

   gnta_select u_select (
      .clock           (clock),
      .reset           (reset),
      .fail_limit      (fail_limit_ff),
      .in_valid        (cand_valid),
      .in_ready        (cand_ready),
      .in_cand         (cand),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_outcome     (outcome),
      .rsp_match_index (rsp_match_index),
      .rsp_fail_count  (rsp_fail_count)
   );

   assign rsp_outcome = outcome;

endmodule

FILE: dv/gnta_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gnta_checker
// Response predictor and scoreboard for the track association unit.
// ----------------------------------------------------------------------------
// Watches the request, response and register ports at each rising edge. Each
// accepted request updates a private copy of the search state. A request that
// closes a message queues its expected verdict. Each accepted response is
// compared field by field with the oldest queued verdict. The number of
// failures and the number of verdicts still due are handed to the top.
// ----------------------------------------------------------------------------
module gnta_checker
   import gnta_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_pose_x,
   input  logic signed [COORD_W-1:0] req_pose_y,
   input  logic signed [COORD_W-1:0] req_est_x,
   input  logic signed [COORD_W-1:0] req_est_y,
   input  logic        [VAR_W-1:0]   req_var_x,
   input  logic        [VAR_W-1:0]   req_var_y,
   input  logic                      req_tracking_active,
   input  logic                      req_has_pose,
   input  logic                      req_last_item,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [1:0]                rsp_outcome,
   input  logic [INDEX_W-1:0]        rsp_match_index,
   input  logic [COUNT_W-1:0]        rsp_fail_count,
   input  logic                      csr_write_enable,
   input  logic [COUNT_W-1:0]        csr_write_data,
   output int                        mismatch_count,
   output int                        pending_count
);

   typedef struct packed {
      outcome_type          outcome;
      logic [INDEX_W-1:0]   index;
      logic [COUNT_W-1:0]   count;
   } verdict_type;

   verdict_type          verdicts_due[$];
   logic [COUNT_W-1:0]   fail_limit_q;
   logic [COUNT_W-1:0]   misses_q;
   logic [DIST_W-1:0]    nearest_sq;
   logic [POS_W-1:0]     nearest_pos;
   logic [POS_W-1:0]     cand_pos;
   logic                 found_q;
   int                   failures = 0;

   always @(posedge clock) begin
      verdict_type              due;
      logic signed [COORD_W:0]  diff_x, diff_y;
      logic        [COORD_W:0]  mag_x, mag_y;
      logic        [DIST_W-1:0] dist_sq;
      logic        [GATE_W-1:0] gate;
      if (reset) begin
         fail_limit_q = FAIL_LIMIT_RESET;
         misses_q     = '0;
         nearest_sq   = '1;
         nearest_pos  = '0;
         cand_pos     = '0;
         found_q      = 1'b0;
         verdicts_due.delete();
      end else begin
         if (csr_write_enable)
            fail_limit_q = csr_write_data;

         // retire responses first: a request taken at this edge cannot be answered yet
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               failures++;
               $display("%0t: response with none due: outcome %0d index %0d count %0d",
                        $time, rsp_outcome, rsp_match_index, rsp_fail_count);
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_outcome != due.outcome) begin
                  failures++;
                  $display("%0t: outcome expected %0d, actual %0d",
                           $time, due.outcome, rsp_outcome);
               end
               if (rsp_match_index != due.index) begin
                  failures++;
                  $display("%0t: match_index expected %0d, actual %0d",
                           $time, due.index, rsp_match_index);
               end
               if (rsp_fail_count != due.count) begin
                  failures++;
                  $display("%0t: fail_count expected %0d, actual %0d",
                           $time, due.count, rsp_fail_count);
               end
            end
         end

         if (req_valid && req_ready) begin
            // candidates beyond the cap are dropped and leave the position alone
            if (req_has_pose && cand_pos < MAX_POSES) begin
               diff_x  = req_pose_x - req_est_x;
               diff_y  = req_pose_y - req_est_y;
               mag_x   = diff_x[COORD_W] ? -diff_x : diff_x;
               mag_y   = diff_y[COORD_W] ? -diff_y : diff_y;
               dist_sq = DIST_W'(mag_x) * DIST_W'(mag_x) + DIST_W'(mag_y) * DIST_W'(mag_y);
               gate    = (GATE_W'(req_var_x) + GATE_W'(req_var_y)) << 2;
               // strict compare: the earliest candidate keeps a tie
               if (dist_sq < nearest_sq && dist_sq < DIST_W'(gate)) begin
                  nearest_sq  = dist_sq;
                  nearest_pos = cand_pos;
                  found_q     = 1'b1;
               end
               cand_pos++;
            end
            if (req_last_item) begin
               due.index = '0;
               if (misses_q >= fail_limit_q) begin
                  misses_q    = '0;
                  due.outcome = OUTCOME_DROP;
               end else if (!req_tracking_active) begin
                  due.outcome = OUTCOME_NO_TRACK;
               end else if (found_q) begin
                  misses_q    = '0;
                  due.outcome = OUTCOME_MATCHED;
                  due.index   = nearest_pos[INDEX_W-1:0];
               end else begin
                  if (misses_q != COUNT_MAX)
                     misses_q++;
                  due.outcome = OUTCOME_NO_MATCH;
               end
               due.count = misses_q;
               verdicts_due = {verdicts_due, due};
               nearest_sq  = '1;
               nearest_pos = '0;
               cand_pos    = '0;
               found_q     = 1'b0;
            end
         end
      end
      mismatch_count <= failures;
      pending_count  <= verdicts_due.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the gated nearest track association unit.
// ----------------------------------------------------------------------------
// A short directed run covers the gate boundary, ties, blank requests, the
// no-track and drop paths and the coordinate and variance extremes. Random
// messages then run through several fail limits, among them zero and the
// maximum, with the limit rewritten only while the block is drained. Both
// channels idle at random apart from one phase with none. Checking is done
// by gnta_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module testbench;
   import gnta_pkg::*;

   localparam int IDLE_PCT        = 23;
   localparam int GAP_PCT         = 15;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASES          = 7;
   localparam int STEADY_PHASE    = 3;
   localparam int ITEMS_PER_PHASE = 165;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic        [VAR_W-1:0]   VAR_MAX   = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_pose_x;
   logic signed [COORD_W-1:0] req_pose_y;
   logic signed [COORD_W-1:0] req_est_x;
   logic signed [COORD_W-1:0] req_est_y;
   logic        [VAR_W-1:0]   req_var_x;
   logic        [VAR_W-1:0]   req_var_y;
   logic                      req_tracking_active;
   logic                      req_has_pose;
   logic                      req_last_item;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_outcome;
   logic [INDEX_W-1:0]        rsp_match_index;
   logic [COUNT_W-1:0]        rsp_fail_count;
   logic                      csr_write_enable;
   logic [COUNT_W-1:0]        csr_write_data;
   int                        mismatch_count;
   int                        pending_count;
   logic                      steady = 1'b0;
   int                        item_total = 0;

   gated_nearest_track_association_unit u_top (.*);

   gnta_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock)
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

   function automatic req_type make_req(
      input logic signed [COORD_W-1:0] px, py, ex, ey,
      input logic        [VAR_W-1:0]   vx, vy,
      input logic                      active, pose, last
   );
      req_type r;
      r = '{px, py, ex, ey, vx, vy, active, pose, last};
      return r;
   endfunction

   // hold the request until it is taken
   task automatic send_request(input req_type r);
      if (!steady && $urandom_range(99) < GAP_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_pose_x          <= r.pose_x;
      req_pose_y          <= r.pose_y;
      req_est_x           <= r.est_x;
      req_est_y           <= r.est_y;
      req_var_x           <= r.var_x;
      req_var_y           <= r.var_y;
      req_tracking_active <= r.tracking_active;
      req_has_pose        <= r.has_pose;
      req_last_item       <= r.last_item;
      req_valid           <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic settle_and_write(input logic [COUNT_W-1:0] limit);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // one detection message; a forced miss is a single candidate with a closed gate, unless a drift reopens it
   task automatic send_message(input logic force_miss);
      req_type     item;
      int unsigned n_cand, sh, amp;
      int          off_x, off_y;
      logic        end_blank;
      item.est_x = COORD_W'($urandom);
      item.est_y = COORD_W'($urandom);
      sh         = $urandom_range(0, 31);
      item.var_x = $urandom >> (31 - sh);
      item.var_y = $urandom >> (31 - sh);
      amp        = 4 << (sh / 2);
      case ($urandom_range(0, 39))
         0:       n_cand = $urandom_range(60, 70);
         1, 2:    n_cand = 0;
         default: n_cand = $urandom_range(1, 8);
      endcase
      if (force_miss) begin
         item.var_x = '0;
         item.var_y = '0;
         n_cand     = 1;
      end
      end_blank = !force_miss && (n_cand == 0 || $urandom_range(0, 4) == 0);
      for (int k = 0; k < n_cand; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            item.pose_x          = COORD_W'($urandom);
            item.pose_y          = COORD_W'($urandom);
            item.tracking_active = 1'($urandom);
            item.has_pose        = 1'b0;
            item.last_item       = 1'b0;
            send_request(item);
            item_total++;
         end
         // drift the estimate now and then; the gate follows each request
         if ($urandom_range(0, 19) == 0) begin
            item.est_x = item.est_x + COORD_W'($urandom_range(0, 2 * amp) - amp);
            item.var_y = $urandom >> (31 - sh);
         end
         // an unchanged pose repeats the last candidate and forms a tie
         if (k == 0 || $urandom_range(0, 9) != 0) begin
            off_x       = int'($urandom_range(0, 2 * amp)) - int'(amp);
            off_y       = int'($urandom_range(0, 2 * amp)) - int'(amp);
            item.pose_x = item.est_x + COORD_W'(off_x);
            item.pose_y = item.est_y + COORD_W'(off_y);
         end
         item.has_pose        = 1'b1;
         item.last_item       = (k == n_cand - 1) && !end_blank;
         item.tracking_active = item.last_item ? (force_miss || $urandom_range(0, 6) != 0)
                                               : 1'($urandom);
         send_request(item);
         item_total++;
      end
      if (end_blank) begin
         item.pose_x          = COORD_W'($urandom);
         item.pose_y          = COORD_W'($urandom);
         item.tracking_active = $urandom_range(0, 6) != 0;
         item.has_pose        = 1'b0;
         item.last_item       = 1'b1;
         send_request(item);
         item_total++;
      end
   endtask

   initial begin
      int                 phase_end;
      logic [COUNT_W-1:0] limit;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_pose_x          = '0;
      req_pose_y          = '0;
      req_est_x           = '0;
      req_est_y           = '0;
      req_var_x           = '0;
      req_var_y           = '0;
      req_tracking_active = 1'b0;
      req_has_pose        = 1'b0;
      req_last_item       = 1'b0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // gate boundary, blank request and ties; the fail limit is still at reset
      send_request(make_req(2, 0, 0, 0, 1, 0, 1, 1, 0));
      send_request(make_req(1, 0, 0, 0, 1, 0, 1, 1, 0));
      send_request(make_req(7, 7, 0, 0, 1, 0, 1, 0, 0));
      send_request(make_req(-1, 0, 0, 0, 1, 0, 1, 1, 0));
      send_request(make_req(0, 1, 0, 0, 1, 0, 1, 1, 1));
      // empty message, then a hit with no track
      send_request(make_req(0, 0, 0, 0, 1, 1, 1, 0, 1));
      send_request(make_req(0, 0, 0, 0, 1, 1, 0, 1, 1));
      // coordinate and variance extremes; a closed gate rejects even zero distance
      send_request(make_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                            VAR_MAX, VAR_MAX, 1, 1, 1));
      send_request(make_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 1, 1, 1));
      send_request(make_req(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 0, 1, 1, 1, 1));
      // wide gate, later candidate nearer
      send_request(make_req(65536, -65536, 0, 0, VAR_MAX, VAR_MAX, 1, 1, 0));
      send_request(make_req(100, 0, 0, 0, VAR_MAX, VAR_MAX, 1, 1, 1));
      // run the counter up to the limit, then drop even with no track
      repeat (5) send_request(make_req(0, 0, 0, 0, 0, 0, 1, 0, 1));
      send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 1));
      item_total = 18;

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       limit = '0;
            1:       limit = COUNT_MAX;
            2:       limit = 1;
            3:       limit = 3;
            4:       limit = FAIL_LIMIT_RESET;
            5:       limit = 2;
            default: limit = COUNT_W'($urandom_range(1, 254));
         endcase
         settle_and_write(limit);
         steady <= (p == STEADY_PHASE);
         // at the top limit, a long miss run is needed to reach the drop
         if (limit == COUNT_MAX) begin
            repeat (int'(COUNT_MAX) + 5) begin
               send_message(1'b1);
            end
         end
         phase_end = item_total + ITEMS_PER_PHASE;
         while (item_total < phase_end)
            send_message(1'b0);
      end

      drain();
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/gnta_pkg.sv
rtl/gnta_dist.sv
rtl/gnta_select.sv
rtl/gated_nearest_track_association_unit.sv
dv/gnta_checker.sv
dv/testbench.sv
